// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked on clock, quiet during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// never true at a clock edge outside reset
`define ASSERT_NEVER(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(expr)) else $error(msg);

`endif

// ===== hdl/fbpa_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fbpa_pkg
// types and constants of the fixed block pool allocator
// ----------------------------------------------------------------------------
package fbpa_pkg;

   localparam int POOL_BLOCKS = 256;
   localparam int IDX_W       = $clog2(POOL_BLOCKS);
   localparam int CNT_W       = 9;

   localparam logic [CNT_W-1:0] POOL_LIMIT = CNT_W'(POOL_BLOCKS);
   localparam logic [CNT_W-1:0] COUNT_MAX  = '1;

   typedef enum logic [1:0] {
      CMD_ALLOC    = 2'd0,
      CMD_FREE     = 2'd1,
      CMD_FREE_ALL = 2'd2,
      CMD_NOP      = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_OOM     = 2'd1,
      ST_BADFREE = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CSR_BLOCKS_IN_USE = 2'd0,
      CSR_BLOCK_SIZE    = 2'd1,
      CSR_POOL_BASE     = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [1:0] cmd;
      logic [7:0] block_index;
   } req_type;

   typedef struct packed {
      logic [7:0]  granted_index;
      logic [31:0] granted_address;
      logic [1:0]  status;
      logic [8:0]  allocated_count;
   } rsp_type;

   // link entry: continuation flag and next index
   typedef struct packed {
      logic             more;
      logic [IDX_W-1:0] next;
   } link_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
      link_type         data;
   } link_wr_type;

endpackage
`default_nettype wire

// ===== hdl/fbpa_link_mem.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fbpa_link_mem
// free list link memory, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module fbpa_link_mem
   import fbpa_pkg::*;
(
   input  wire logic              clock,
   input  wire link_wr_type       wr,
   input  wire logic              rd_en,
   input  wire logic [IDX_W-1:0]  rd_addr,
   output link_type               rd_data
);

   link_type mem [POOL_BLOCKS];
   link_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== hdl/fixed_block_pool_allocator_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator_core
// fixed-size block pool manager with a lifo free list kept in link memory
// ----------------------------------------------------------------------------
// usage:
//   a transaction is taken at a rising edge with start high and busy low;
//   req_data carries the command and, for a free, the block index.
//   every transaction gives exactly one result, shown on rsp_data for one
//   cycle with rsp_strobe high; the receiver cannot stall it.
//   free, free-all, no-op and out-of-memory answer in the cycle after accept,
//   and busy stays low so a new transaction can follow at once.
//   a granted allocate holds busy through S_MULT and S_RESP (index times
//   block size through a registered multiplier, then the base add) and
//   registers its answer in S_RESP; a pop from the free list starts the
//   link memory read at accept and loads the next head from it in S_MULT.
//   csr_we/csr_index/csr_wdata write the pool size, block size and base;
//   write them only while no transaction is pending.
//   reset (synchronous, high) empties the free list, clears the count and
//   restores the register defaults; link memory needs no clearing pass.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fixed_block_pool_allocator_core
   import fbpa_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire req_type     req_data,
   output logic             rsp_strobe,
   output rsp_type          rsp_data,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_wdata
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_MULT,
      S_RESP
   } state_type;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  blocks_in_use_ff;
   logic [15:0]       block_size_ff;
   logic [31:0]       pool_base_ff;
   logic [CNT_W-1:0]  untouched_ff, untouched_in;
   logic [IDX_W-1:0]  head_ff, head_in;
   logic              nonempty_ff, nonempty_in;
   logic [CNT_W-1:0]  live_ff, live_in;
   logic              pop_ff, pop_in;
   logic [IDX_W-1:0]  got_ff, got_in;
   logic [23:0]       prod_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   logic              accept;
   logic              rd_en;
   logic [CNT_W-1:0]  limit;
   link_wr_type       link_wr;
   link_type          link_rd;

   fbpa_link_mem u_link_mem (
      .clock   (clock),
      .wr      (link_wr),
      .rd_en   (rd_en),
      .rd_addr (head_ff),
      .rd_data (link_rd)
   );

   assign busy       = (state_ff != S_IDLE);
   assign accept     = start && !busy;
   assign limit      = (blocks_in_use_ff > POOL_LIMIT) ? POOL_LIMIT : blocks_in_use_ff;
   assign rsp_strobe = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      untouched_in = untouched_ff;
      head_in      = head_ff;
      nonempty_in  = nonempty_ff;
      live_in      = live_ff;
      pop_in       = pop_ff;
      got_in       = got_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      rd_en        = 1'b0;
      link_wr      = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rsp_data_in.granted_index   = '0;
               rsp_data_in.granted_address = '0;
               rsp_data_in.status          = ST_OK;
               rsp_valid_in                = 1'b1;
               unique case (cmd_type'(req_data.cmd))
                  CMD_ALLOC: begin
                     priority if (untouched_ff < limit) begin
                        got_in       = untouched_ff[IDX_W-1:0];
                        untouched_in = untouched_ff + 1'b1;
                        pop_in       = 1'b0;
                        state_in     = S_MULT;
                        rsp_valid_in = 1'b0;
                     end else if (nonempty_ff) begin
                        got_in       = head_ff;
                        pop_in       = 1'b1;
                        rd_en        = 1'b1;
                        state_in     = S_MULT;
                        rsp_valid_in = 1'b0;
                     end else begin
                        rsp_data_in.status = ST_OOM;
                     end
                     if (state_in == S_MULT && live_ff != COUNT_MAX) begin
                        live_in = live_ff + 1'b1;
                     end
                  end
                  CMD_FREE: begin
                     if ({1'b0, req_data.block_index} >= limit || live_ff == '0) begin
                        rsp_data_in.status = ST_BADFREE;
                     end else begin
                        link_wr.en        = 1'b1;
                        link_wr.addr      = req_data.block_index;
                        link_wr.data.next = head_ff;
                        link_wr.data.more = nonempty_ff;
                        head_in           = req_data.block_index;
                        nonempty_in       = 1'b1;
                        live_in           = live_ff - 1'b1;
                     end
                  end
                  CMD_FREE_ALL: begin
                     untouched_in = '0;
                     head_in      = '0;
                     nonempty_in  = 1'b0;
                     live_in      = '0;
                  end
                  default: begin
                  end
               endcase
               rsp_data_in.allocated_count = live_in;
            end
         end
         S_MULT: begin
            if (pop_ff) begin
               head_in     = link_rd.next;
               nonempty_in = link_rd.more;
            end
            state_in = S_RESP;
         end
         S_RESP: begin
            rsp_data_in.granted_index   = got_ff;
            rsp_data_in.granted_address = pool_base_ff + {8'd0, prod_ff};
            rsp_data_in.status          = ST_OK;
            rsp_data_in.allocated_count = live_ff;
            rsp_valid_in                = 1'b1;
            state_in                    = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         untouched_ff     <= '0;
         head_ff          <= '0;
         nonempty_ff      <= 1'b0;
         live_ff          <= '0;
         pop_ff           <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         blocks_in_use_ff <= POOL_LIMIT;
         block_size_ff    <= 16'd64;
         pool_base_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         untouched_ff <= untouched_in;
         head_ff      <= head_in;
         nonempty_ff  <= nonempty_in;
         live_ff      <= live_in;
         pop_ff       <= pop_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index_type'(csr_index))
               CSR_BLOCKS_IN_USE: blocks_in_use_ff <= csr_wdata[CNT_W-1:0];
               CSR_BLOCK_SIZE:    block_size_ff    <= csr_wdata[15:0];
               CSR_POOL_BASE:     pool_base_ff     <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      got_ff      <= got_in;
      rsp_data_ff <= rsp_data_in;
      prod_ff     <= got_ff * block_size_ff;
   end

   `ASSERT_CLK(a_strobe_idle, rsp_strobe |-> state_ff == S_IDLE, "strobe while working")
   `ASSERT_CLK(a_resp_strobe, state_ff == S_RESP |=> rsp_strobe, "granted result not shown")
   `ASSERT_CLK(a_quick_strobe, (accept && state_in == S_IDLE) |=> rsp_strobe,
      "immediate result missing")
   `ASSERT_NEVER(a_rd_wr_clash, rd_en && link_wr.en, "link read and write together")

endmodule
`default_nettype wire

// ===== tb/tb_fixed_block_pool_allocator_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_fixed_block_pool_allocator_core
// self-checking bench for the fixed block pool allocator: a scripted opening
// (empty pool, wrap of the address, lifo reuse, out of memory, bad frees)
// followed by random phases under changing pool settings and random gaps;
// every response is compared against a scripted expectation or an in-bench model of the allocator
// ----------------------------------------------------------------------------
module tb_fixed_block_pool_allocator_core;
   import fbpa_pkg::*;

   localparam int ITEM_TARGET   = 1550;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 4;
   localparam int TAIL_CYCLES   = 8;
   localparam int MAX_REPORTS   = 40;
   localparam int SCRIPT_LEN    = 30;
   localparam logic [1:0] CSR_UNUSED = 2'd3;

   typedef enum logic {ROW_TXN, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type kind;
      logic [1:0]   csr_index;
      logic [31:0]  csr_value;
      req_type      req;
      logic         preset;
      rsp_type      want;
   } script_row_type;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        start     = 1'b0;
   req_type     req_data  = '0;
   logic        csr_we    = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [31:0] csr_wdata = '0;
   logic        busy;
   logic        rsp_strobe;
   rsp_type     rsp_data;

   // pool model state and settings
   logic [8:0]  cfg_pool_blocks;
   logic [15:0] cfg_block_size;
   logic [31:0] cfg_pool_base;
   logic [8:0]  fresh_next;
   logic [7:0]  list_head;
   logic        list_nonempty;
   logic [8:0]  live_count;
   logic [7:0]  link_next [POOL_BLOCKS];
   logic        link_more [POOL_BLOCKS];

   rsp_type    pending_responses [$];
   logic [7:0] held_blocks [$];

   int error_count    = 0;
   int accepted_count = 0;
   int checked_count  = 0;
   int grant_count    = 0;
   int pop_count      = 0;
   int oom_count      = 0;
   int bad_free_count = 0;
   int phase_count    = 0;
   int cycle_count    = 0;

   script_row_type script [SCRIPT_LEN] = '{
      '{ROW_TXN, '0, '0, '{CMD_FREE, 8'd0}, 1'b1, '{8'd0, 32'd0, ST_BADFREE, 9'd0}},
      '{ROW_TXN, '0, '0, '{CMD_ALLOC, 8'd0}, 1'b1, '{8'd0, 32'd0, ST_OK, 9'd1}},
      '{ROW_TXN, '0, '0, '{CMD_ALLOC, 8'hFF}, 1'b1, '{8'd1, 32'd64, ST_OK, 9'd2}},
      '{ROW_TXN, '0, '0, '{CMD_FREE, 8'd255}, 1'b1, '{8'd0, 32'd0, ST_OK, 9'd1}},
      '{ROW_TXN, '0, '0, '{CMD_FREE, 8'd1}, 1'b1, '{8'd0, 32'd0, ST_OK, 9'd0}},
      '{ROW_TXN, '0, '0, '{CMD_FREE, 8'd0}, 1'b1, '{8'd0, 32'd0, ST_BADFREE, 9'd0}},
      '{ROW_TXN, '0, '0, '{CMD_NOP, 8'hFF}, 1'b1, '{8'd0, 32'd0, ST_OK, 9'd0}},
      '{ROW_TXN, '0, '0, '{CMD_ALLOC, 8'd0}, 1'b1, '{8'd2, 32'd128, ST_OK, 9'd1}},
      '{ROW_TXN, '0, '0, '{CMD_FREE_ALL, 8'hAA}, 1'b1, '{8'd0, 32'd0, ST_OK, 9'd0}},
      '{ROW_TXN, '0, '0, '{CMD_ALLOC, 8'd0}, 1'b1, '{8'd0, 32'd0, ST_OK, 9'd1}},
      '{ROW_CSR, CSR_BLOCKS_IN_USE, 32'hFFFF_FE02, '0, 1'b0, '0},
      '{ROW_CSR, CSR_BLOCK_SIZE, 32'h0001_FFFF, '0, 1'b0, '0},
      '{ROW_CSR, CSR_POOL_BASE, 32'hFFFF_FFF0, '0, 1'b0, '0},
      '{ROW_CSR, CSR_UNUSED, 32'hA5A5_5A5A, '0, 1'b0, '0},
      '{ROW_TXN, '0, '0, '{CMD_FREE_ALL, 8'h55}, 1'b1, '{8'd0, 32'd0, ST_OK, 9'd0}},
      '{ROW_TXN, '0, '0, '{CMD_ALLOC, 8'd0}, 1'b1,
        '{8'd0, 32'hFFFF_FFF0, ST_OK, 9'd1}},
      '{ROW_TXN, '0, '0, '{CMD_ALLOC, 8'd0}, 1'b1,
        '{8'd1, 32'h0000_FFEF, ST_OK, 9'd2}},
      '{ROW_TXN, '0, '0, '{CMD_ALLOC, 8'd0}, 1'b1, '{8'd0, 32'd0, ST_OOM, 9'd2}},
      '{ROW_TXN, '0, '0, '{CMD_FREE, 8'd2}, 1'b1, '{8'd0, 32'd0, ST_BADFREE, 9'd2}},
      '{ROW_TXN, '0, '0, '{CMD_FREE, 8'd1}, 1'b0, '0},
      '{ROW_TXN, '0, '0, '{CMD_FREE, 8'd0}, 1'b0, '0},
      '{ROW_TXN, '0, '0, '{CMD_ALLOC, 8'd0}, 1'b0, '0},
      '{ROW_TXN, '0, '0, '{CMD_ALLOC, 8'd0}, 1'b0, '0},
      '{ROW_CSR, CSR_BLOCKS_IN_USE, 32'd0, '0, 1'b0, '0},
      '{ROW_TXN, '0, '0, '{CMD_ALLOC, 8'd0}, 1'b1, '{8'd0, 32'd0, ST_OOM, 9'd2}},
      '{ROW_TXN, '0, '0, '{CMD_FREE, 8'd0}, 1'b1, '{8'd0, 32'd0, ST_BADFREE, 9'd2}},
      '{ROW_CSR, CSR_BLOCKS_IN_USE, 32'h0000_01FF, '0, 1'b0, '0},
      '{ROW_CSR, CSR_BLOCK_SIZE, 32'd1, '0, 1'b0, '0},
      '{ROW_CSR, CSR_POOL_BASE, 32'd0, '0, 1'b0, '0},
      '{ROW_TXN, '0, '0, '{CMD_ALLOC, 8'd0}, 1'b0, '0}
   };

   fixed_block_pool_allocator_core uut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void reset_pool_model();
      cfg_pool_blocks = 9'd256;
      cfg_block_size  = 16'd64;
      cfg_pool_base   = 32'd0;
      fresh_next      = '0;
      list_head       = '0;
      list_nonempty   = 1'b0;
      live_count      = '0;
      foreach (link_next[i]) begin
         link_next[i] = '0;
         link_more[i] = 1'b0;
      end
   endfunction

   // response of the pool to one transaction, advancing the model state
   function automatic rsp_type pool_response(input req_type r);
      rsp_type    resp;
      logic [8:0] limit;
      logic [7:0] got;
      logic       granted;
      resp    = '0;
      got     = '0;
      granted = 1'b0;
      limit   = (cfg_pool_blocks > POOL_LIMIT) ? POOL_LIMIT : cfg_pool_blocks;
      case (r.cmd)
         CMD_ALLOC: begin
            if (fresh_next < limit) begin
               got        = fresh_next[7:0];
               fresh_next = fresh_next + 9'd1;
               granted    = 1'b1;
            end else if (list_nonempty) begin
               got           = list_head;
               list_head     = link_next[got];
               list_nonempty = link_more[got];
               granted       = 1'b1;
               pop_count++;
            end else begin
               resp.status = ST_OOM;
               oom_count++;
            end
            if (granted) begin
               if (live_count < COUNT_MAX) live_count = live_count + 9'd1;
               grant_count++;
            end
         end
         CMD_FREE: begin
            if ({1'b0, r.block_index} >= limit || live_count == 9'd0) begin
               resp.status = ST_BADFREE;
               bad_free_count++;
            end else begin
               link_next[r.block_index] = list_head;
               link_more[r.block_index] = list_nonempty;
               list_head     = r.block_index;
               list_nonempty = 1'b1;
               live_count    = live_count - 9'd1;
            end
         end
         CMD_FREE_ALL: begin
            fresh_next    = '0;
            list_head     = '0;
            list_nonempty = 1'b0;
            live_count    = '0;
         end
         default: ;
      endcase
      if (granted) begin
         resp.granted_index   = got;
         resp.granted_address = cfg_pool_base + 32'(got) * 32'(cfg_block_size);
      end
      resp.allocated_count = live_count;
      return resp;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      error_count++;
      if (error_count <= MAX_REPORTS)
         $display("[%0t] %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
   endtask

   task automatic issue(input req_type r, input logic preset, input rsp_type want);
      rsp_type modeled;
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy !== 1'b0);
      modeled = pool_response(r);
      if (r.cmd == CMD_ALLOC && modeled.status == ST_OK)
         held_blocks.insert(held_blocks.size(), modeled.granted_index);
      if (r.cmd == CMD_FREE_ALL) held_blocks.delete();
      pending_responses.insert(pending_responses.size(), preset ? want : modeled);
      accepted_count++;
   endtask

   task automatic idle_gap(input logic quiet);
      int pick;
      int n;
      pick = $urandom_range(99);
      if (quiet || pick < 55) n = 0;
      else if (pick < 88) n = $urandom_range(1, 3);
      else n = $urandom_range(4, 25);
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic drain();
      start <= 1'b0;
      while (pending_responses.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [31:0] value);
      csr_index <= idx;
      csr_wdata <= value;
      csr_we    <= 1'b1;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_BLOCKS_IN_USE: cfg_pool_blocks = value[8:0];
         CSR_BLOCK_SIZE:    cfg_block_size  = value[15:0];
         CSR_POOL_BASE:     cfg_pool_base   = value;
         default: ;
      endcase
      @(posedge clock);
   endtask

   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_strobe !== 1'b0) begin
         if (pending_responses.size() == 0) begin
            report_mismatch("response with nothing outstanding", rsp_data.granted_address, '0);
         end else begin
            want = pending_responses.pop_front();
            checked_count++;
            if (rsp_data.granted_index !== want.granted_index)
               report_mismatch("granted_index", 32'(rsp_data.granted_index),
                               32'(want.granted_index));
            if (rsp_data.granted_address !== want.granted_address)
               report_mismatch("granted_address", rsp_data.granted_address,
                               want.granted_address);
            if (rsp_data.status !== want.status)
               report_mismatch("status", 32'(rsp_data.status), 32'(want.status));
            if (rsp_data.allocated_count !== want.allocated_count)
               report_mismatch("allocated_count", 32'(rsp_data.allocated_count),
                               32'(want.allocated_count));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("run stopped at the cycle limit with %0d responses outstanding",
                  pending_responses.size());
         $display("simulation failed");
         $finish;
      end
   end

   initial begin : stimulus
      req_type     r;
      int          pick;
      int          alloc_pct;
      int          phase_items;
      int          k;
      logic        quiet;
      logic [8:0]  blocks;
      logic [15:0] bsize;
      logic [31:0] base;
      reset_pool_model();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (script[i]) begin
         if (script[i].kind == ROW_CSR) begin
            drain();
            write_csr(script[i].csr_index, script[i].csr_value);
         end else begin
            issue(script[i].req, script[i].preset, script[i].want);
            idle_gap(1'b0);
         end
      end

      while (accepted_count < ITEM_TARGET) begin
         drain();
         phase_count++;
         pick = $urandom_range(99);
         if (pick < 10) blocks = '0;
         else if (pick < 45) blocks = 9'($urandom_range(1, 4));
         else if (pick < 70) blocks = 9'($urandom_range(5, 32));
         else if (pick < 75) blocks = 9'($urandom_range(33, 255));
         else if (pick < 88) blocks = 9'd256;
         else blocks = 9'($urandom_range(257, 511));
         pick = $urandom_range(99);
         if (pick < 5) bsize = '0;
         else if (pick < 25) bsize = 16'd1;
         else if (pick < 45) bsize = 16'hFFFF;
         else bsize = 16'($urandom_range(1, 16'hFFFF));
         pick = $urandom_range(99);
         if (pick < 15) base = '0;
         else if (pick < 30) base = 32'hFFFF_FFFF;
         else base = $urandom;
         write_csr(CSR_BLOCKS_IN_USE, {23'($urandom), blocks});
         write_csr(CSR_BLOCK_SIZE, {16'($urandom), bsize});
         write_csr(CSR_POOL_BASE, base);

         case ($urandom_range(3))
            0: alloc_pct = 35;
            1: alloc_pct = 50;
            2: alloc_pct = 65;
            default: alloc_pct = 90;
         endcase
         quiet       = ($urandom_range(3) == 0);
         phase_items = $urandom_range(80, 160);
         repeat (phase_items) begin
            pick          = $urandom_range(99);
            r.block_index = 8'($urandom);
            if (pick < alloc_pct) begin
               r.cmd = CMD_ALLOC;
            end else if (pick < 97) begin
               r.cmd = CMD_FREE;
               if (held_blocks.size() > 0 && $urandom_range(9) < 8) begin
                  k = $urandom_range(held_blocks.size() - 1);
                  r.block_index = held_blocks[k];
                  held_blocks.delete(k);
               end
            end else if (pick < 99) begin
               r.cmd = CMD_FREE_ALL;
            end else begin
               r.cmd = CMD_NOP;
            end
            issue(r, 1'b0, '0);
            if ($urandom_range(199) == 0) drain();
            else idle_gap(quiet);
         end
      end

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("%0d transactions over %0d random phases: %0d grants, %0d of them reused",
               accepted_count, phase_count, grant_count, pop_count);
      $display("%0d out of memory, %0d rejected frees, %0d responses compared, %0d errors",
               oom_count, bad_free_count, checked_count, error_count);
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ===== fixed_block_pool_allocator_core.f =====
+incdir+hdl
hdl/fbpa_pkg.sv
hdl/fbpa_link_mem.sv
hdl/fixed_block_pool_allocator_core.sv
tb/tb_fixed_block_pool_allocator_core.sv
